@@ rtl/rtiq_pkg.sv @@
// Package for the relay toggle input qualifier.
// Holds the transaction payload types, register codes, reset values and limits.
// No dependencies; every other file of the block uses it.
package rtiq_pkg;

	localparam int PRESS_W  = 10;
	localparam int STABLE_W = 8;
	localparam int CFG_W    = 10;

	localparam logic [PRESS_W-1:0]  PRESS_TICKS_MAX  = '1;
	localparam logic [STABLE_W-1:0] STABLE_TICKS_MAX = '1;

	localparam logic                DETACHED_RST     = 1'b0;
	localparam logic [PRESS_W-1:0]  PRESS_MIN_RST    = 10'd90;
	localparam logic [PRESS_W-1:0]  PRESS_MAX_RST    = 10'd900;
	localparam logic [STABLE_W-1:0] SWITCH_ATTACK_RST = 8'd7;

	typedef enum logic [1:0] {
		REG_DETACHED      = 2'd0,
		REG_PRESS_MIN     = 2'd1,
		REG_PRESS_MAX     = 2'd2,
		REG_SWITCH_ATTACK = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic button_level;
		logic switch_level;
		logic remote_valid;
		logic remote_on;
	} sample_t;

	typedef struct packed {
		logic relay_on;
		logic relay_changed;
		logic contact_closed;
		logic contact_changed;
	} result_t;

	// Status handed from the switch debouncer to the relay logic
	typedef struct packed {
		logic changed;
		logic level;
	} sw_status_t;

endpackage

@@ rtl/rtiq_if.sv @@
// Valid/ready channel interfaces for the relay toggle input qualifier.
// Depends on rtiq_pkg for the payload types.
interface rtiq_sample_if;
	logic             valid;
	logic             ready;
	rtiq_pkg::sample_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface rtiq_result_if;
	logic             valid;
	logic             ready;
	rtiq_pkg::result_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/relay_toggle_input_qualifier.sv @@
// Relay toggle input qualifier, top level.
// Each sample transaction passes the input register, then the result register.
// Throughput: one sample transaction per cycle while the result channel does not stall; the tick
// state updates as an item passes from the input register into the result register.
// Reset: arst_n clears both stages, the button and switch trackers, the relay and
// restores the configuration registers to their defaults.
module relay_toggle_input_qualifier (
	input  logic                         clk,
	input  logic                         arst_n,
	rtiq_sample_if.sink                  sample,
	rtiq_result_if.source                result,
	input  logic                         cfg_we,
	input  rtiq_pkg::cfg_reg_t           cfg_index,
	input  logic [rtiq_pkg::CFG_W-1:0]   cfg_data
);
	import rtiq_pkg::*;

	logic                detached_q;
	logic [PRESS_W-1:0]  press_min_q;
	logic [PRESS_W-1:0]  press_max_q;
	logic [STABLE_W-1:0] attack_q;

	logic       valid_s1;
	sample_t    data_s1;
	logic       valid_s2;
	result_t    data_s2;
	logic       relay_q;

	logic       out_free;
	logic       adv;
	logic       btn_toggle;
	sw_status_t sw_status;
	logic       sw_toggle;
	logic       relay_nxt;
	logic       relay_chg;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			detached_q  <= DETACHED_RST;
			press_min_q <= PRESS_MIN_RST;
			press_max_q <= PRESS_MAX_RST;
			attack_q    <= SWITCH_ATTACK_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DETACHED:      detached_q  <= cfg_data[0];
				REG_PRESS_MIN:     press_min_q <= cfg_data[PRESS_W-1:0];
				REG_PRESS_MAX:     press_max_q <= cfg_data[PRESS_W-1:0];
				REG_SWITCH_ATTACK: attack_q    <= cfg_data[STABLE_W-1:0];
				default: ;
			endcase
		end
	end

	// Handshake: the result register frees when empty or taken
	assign out_free     = !valid_s2 || result.ready;
	assign adv          = valid_s1 && out_free;
	assign sample.ready = !valid_s1 || out_free;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			data_s1 <= sample.data;
		end
	end

	rtiq_button u_button (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.level     (data_s1.button_level),
		.press_min (press_min_q),
		.press_max (press_max_q),
		.toggle    (btn_toggle)
	);

	rtiq_switch u_switch (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.level  (data_s1.switch_level),
		.attack (attack_q),
		.status (sw_status)
	);

	// Combine button and switch toggles, then let a remote command override
	assign sw_toggle = sw_status.changed && !detached_q;

	always_comb begin
		relay_nxt = relay_q ^ btn_toggle ^ sw_toggle;
		relay_chg = btn_toggle || sw_toggle || data_s1.remote_valid;
		if (data_s1.remote_valid) begin
			relay_nxt = data_s1.remote_on;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relay_q <= 1'b0;
		end else if (adv) begin
			relay_q <= relay_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s2.relay_on        <= relay_nxt;
			data_s2.relay_changed   <= relay_chg;
			data_s2.contact_closed  <= ~sw_status.level;
			data_s2.contact_changed <= sw_status.changed;
		end
	end

	assign result.valid = valid_s2;
	assign result.data  = data_s2;

	// Relay holds unless a toggle or remote command passes through
	a_relay_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !relay_chg) |=> $stable(relay_q))
		else $error("relay moved without a reported change");

	// Input is refused only with both stages occupied
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!sample.ready |-> (valid_s1 && valid_s2))
		else $error("input stalled while a stage was free");

	// A reported relay change without remote or switch must come from the button
	a_button_src: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && relay_chg && !data_s1.remote_valid && !sw_toggle) |-> btn_toggle)
		else $error("relay change without a source");

	// Accepted contact state moves only with a reported change
	a_contact_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !sw_status.changed) |=> $stable(u_switch.acc_level_q))
		else $error("contact state moved without a reported change");

endmodule

@@ rtl/rtiq_button.sv @@
// Push button press timer: counts ticks while held, judges the press on release.
// Depends on rtiq_pkg for widths and the saturation limit.
module rtiq_button (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           level,
	input  logic [rtiq_pkg::PRESS_W-1:0]   press_min,
	input  logic [rtiq_pkg::PRESS_W-1:0]   press_max,
	output logic                           toggle
);
	import rtiq_pkg::*;

	logic               prev_level_q;
	logic [PRESS_W-1:0] ticks_q;
	logic               done_q;
	logic [PRESS_W-1:0] ticks_inc;
	logic [PRESS_W-1:0] ticks_nxt;
	logic               done_nxt;

	// Advance the hold counter, then act on an edge of the button level
	always_comb begin
		ticks_inc = ticks_q;
		if (!prev_level_q && ticks_q < PRESS_TICKS_MAX) begin
			ticks_inc = ticks_q + PRESS_W'(1);
		end
		ticks_nxt = ticks_inc;
		done_nxt  = done_q;
		toggle    = 1'b0;
		if (level != prev_level_q) begin
			if (!level) begin
				ticks_nxt = '0;
				done_nxt  = 1'b0;
			end else if (ticks_inc >= press_min && ticks_inc <= press_max && !done_q) begin
				toggle   = 1'b1;
				done_nxt = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_level_q <= 1'b1;
			ticks_q      <= '0;
			done_q       <= 1'b0;
		end else if (en) begin
			prev_level_q <= level;
			ticks_q      <= ticks_nxt;
			done_q       <= done_nxt;
		end
	end

endmodule

@@ rtl/rtiq_switch.sv @@
// Wall switch debouncer: accepts a new level once it has held still long enough.
// Depends on rtiq_pkg for widths, the saturation limit and the status struct.
module rtiq_switch (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            level,
	input  logic [rtiq_pkg::STABLE_W-1:0]   attack,
	output rtiq_pkg::sw_status_t            status
);
	import rtiq_pkg::*;

	logic                prev_level_q;
	logic                acc_level_q;
	logic [STABLE_W-1:0] stable_q;
	logic [STABLE_W-1:0] stable_nxt;

	// Restart the stability count on a change, otherwise count and test
	always_comb begin
		status.changed = 1'b0;
		status.level   = acc_level_q;
		stable_nxt     = '0;
		if (level == prev_level_q) begin
			stable_nxt = stable_q;
			if (stable_q < STABLE_TICKS_MAX) begin
				stable_nxt = stable_q + STABLE_W'(1);
			end
			if (level != acc_level_q && stable_nxt >= attack) begin
				status.changed = 1'b1;
				status.level   = level;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_level_q <= 1'b1;
			acc_level_q  <= 1'b1;
			stable_q     <= '0;
		end else if (en) begin
			prev_level_q <= level;
			acc_level_q  <= status.level;
			stable_q     <= stable_nxt;
		end
	end

endmodule

@@ verif/rtiq_checker.sv @@
// Scoreboard for the relay toggle input qualifier: watches both channels and the register port.
// Keeps its own copy of the tick state to predict each result, then compares field by field.
// Depends on rtiq_pkg and the channel interfaces in rtiq_if.
module rtiq_checker
	import rtiq_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	rtiq_sample_if               smp,
	rtiq_result_if               res,
	input  logic                 cfg_we,
	input  cfg_reg_t             cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   errors,
	output int                   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	// Shadow configuration
	logic                detached;
	logic [PRESS_W-1:0]  press_min;
	logic [PRESS_W-1:0]  press_max;
	logic [STABLE_W-1:0] attack;

	// Shadow tick state
	logic                prev_btn;
	logic [PRESS_W-1:0]  press_ticks;
	logic                press_done;
	logic                prev_sw;
	logic                accepted_sw;
	logic [STABLE_W-1:0] stable_ticks;
	logic                relay;

	result_t relay_results_q[$];
	int      results_seen;

	task automatic report(input string msg);
		$display("ERROR %0t: %s", $realtime, msg);
		errors++;
	endtask

	// Advance the shadow state by one tick and return the result it produces
	function automatic result_t advance_tick(input sample_t s);
		result_t r;
		r = '0;

		// Count held ticks, judge the press on release
		if (!prev_btn && press_ticks != PRESS_TICKS_MAX)
			press_ticks = press_ticks + 1'b1;
		if (s.button_level != prev_btn) begin
			if (!s.button_level) begin
				press_ticks = '0;
				press_done  = 1'b0;
			end else if (press_ticks >= press_min && press_ticks <= press_max && !press_done) begin
				relay = ~relay;
				r.relay_changed = 1'b1;
				press_done = 1'b1;
			end
			prev_btn = s.button_level;
		end

		// Accept a switch level once it has been stable long enough
		if (s.switch_level != prev_sw) begin
			prev_sw = s.switch_level;
			stable_ticks = '0;
		end else begin
			if (stable_ticks != STABLE_TICKS_MAX)
				stable_ticks = stable_ticks + 1'b1;
			if (s.switch_level != accepted_sw && stable_ticks >= attack) begin
				accepted_sw = s.switch_level;
				r.contact_changed = 1'b1;
				if (!detached) begin
					relay = ~relay;
					r.relay_changed = 1'b1;
				end
			end
		end

		// Remote command overrides everything
		if (s.remote_valid) begin
			relay = s.remote_on;
			r.relay_changed = 1'b1;
		end

		r.relay_on       = relay;
		r.contact_closed = ~accepted_sw;
		return r;
	endfunction

	task automatic compare_field(input string name, input logic exp_v, input logic got_v);
		if (exp_v !== got_v)
			report($sformatf("result %0d: %s expected %0b got %0b",
				results_seen, name, exp_v, got_v));
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t exp_r;
		result_t got_r;
		if (!arst_n) begin
			detached     = DETACHED_RST;
			press_min    = PRESS_MIN_RST;
			press_max    = PRESS_MAX_RST;
			attack       = SWITCH_ATTACK_RST;
			prev_btn     = 1'b1;
			press_ticks  = '0;
			press_done   = 1'b0;
			prev_sw      = 1'b1;
			accepted_sw  = 1'b1;
			stable_ticks = '0;
			relay        = 1'b0;
			relay_results_q.delete();
			results_seen = 0;
			errors       = 0;
			outstanding  = 0;
		end else begin
			// Track register writes
			if (cfg_we) begin
				case (cfg_index)
					REG_DETACHED:      detached  = cfg_data[0];
					REG_PRESS_MIN:     press_min = cfg_data[PRESS_W-1:0];
					REG_PRESS_MAX:     press_max = cfg_data[PRESS_W-1:0];
					REG_SWITCH_ATTACK: attack    = cfg_data[STABLE_W-1:0];
					default: ;
				endcase
			end

			// Compare every accepted result transaction with the oldest prediction
			if (res.valid && res.ready) begin
				got_r = res.data;
				if (relay_results_q.size() == 0) begin
					report($sformatf("result %0d arrived with no tick pending", results_seen));
				end else begin
					exp_r = relay_results_q.pop_front();
					compare_field("relay_on",        exp_r.relay_on,        got_r.relay_on);
					compare_field("relay_changed",   exp_r.relay_changed,   got_r.relay_changed);
					compare_field("contact_closed",  exp_r.contact_closed,  got_r.contact_closed);
					compare_field("contact_changed", exp_r.contact_changed, got_r.contact_changed);
				end
				results_seen++;
			end

			// Predict on every accepted sample transaction
			if (smp.valid && smp.ready)
				relay_results_q.push_back(advance_tick(smp.data));

			outstanding = relay_results_q.size();
		end
	end

endmodule

@@ verif/testbench.sv @@
// Top of the relay toggle input qualifier testbench: clock, reset, tick stimulus and verdict.
// Drives directed and random button, switch and remote sequences through several settings.
// Depends on rtiq_pkg, rtiq_if, the block and rtiq_checker.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import rtiq_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 150;

	logic             clk    = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we;
	cfg_reg_t         cfg_index;
	logic [CFG_W-1:0] cfg_data;

	int errors;
	int outstanding;
	int cycles;
	int burst_left;
	logic sw_now;
	logic hold_req;

	rtiq_sample_if smp();
	rtiq_result_if res();

	relay_toggle_input_qualifier dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (smp),
		.result    (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	rtiq_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.smp         (smp),
		.res         (res),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.errors      (errors),
		.outstanding (outstanding)
	);

	always #1 clk = ~clk;

	// Stop a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Receiver: stall on a changing pattern, with one long hold-off on request
	initial begin
		int mode;
		int mode_left;
		int hold_left;
		int phase;
		logic hold_done;
		mode      = 0;
		mode_left = 0;
		hold_left = 0;
		phase     = 0;
		hold_done = 1'b0;
		res.ready = 1'b0;
		forever begin
			@(negedge clk);
			phase++;
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				res.ready = 1'b0;
				hold_left--;
			end else begin
				if (mode_left == 0) begin
					mode      = $urandom_range(0, 3);
					mode_left = $urandom_range(8, 80);
				end
				mode_left--;
				case (mode)
					0: res.ready = 1'b1;
					1: res.ready = 1'($urandom_range(0, 1));
					2: res.ready = ($urandom_range(0, 3) == 0);
					default: res.ready = (phase % 5) < 3;
				endcase
			end
		end
	end

	// Offer one tick, in bursts separated by random gaps; return once accepted
	task automatic send_tick(input sample_t s);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			repeat (gap) begin
				@(negedge clk);
				smp.valid = 1'b0;
			end
		end
		burst_left--;
		@(negedge clk);
		smp.valid = 1'b1;
		smp.data  = s;
		do @(posedge clk); while (!smp.ready);
	endtask

	task automatic tick(input logic btn, input logic sw, input logic rv, input logic ron);
		sample_t s;
		s.button_level = btn;
		s.switch_level = sw;
		s.remote_valid = rv;
		s.remote_on    = ron;
		send_tick(s);
	endtask

	// Tick with a rare remote command on top
	task automatic rnd_tick(input logic btn, input logic sw);
		tick(btn, sw, $urandom_range(0, 29) == 0, 1'($urandom_range(0, 1)));
	endtask

	// Drop valid and let every pending result come back before touching registers
	task automatic drain();
		@(negedge clk);
		smp.valid = 1'b0;
		wait (outstanding == 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input int val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val[CFG_W-1:0];
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	// Idle the block, then load all four registers; unused high bits carry noise
	task automatic configure(input int det, input int pmin, input int pmax, input int att);
		drain();
		write_reg(REG_DETACHED, ($urandom_range(0, 511) << 1) | det);
		write_reg(REG_PRESS_MIN, pmin);
		write_reg(REG_PRESS_MAX, pmax);
		write_reg(REG_SWITCH_ATTACK, ($urandom_range(0, 3) << 8) | att);
	endtask

	// Mostly well-formed presses and switch flips, the rest idle and noise
	task automatic run_random(input int n, input int dlo, input int dhi,
			input int hlo, input int hhi);
		int sent;
		int kind;
		int d;
		int flip_at;
		sample_t s;
		sent = 0;
		while (sent < n) begin
			kind = $urandom_range(0, 9);
			if (kind < 5) begin
				// Press held for d ticks, sometimes with a switch flip in the middle
				d = $urandom_range(dlo, dhi);
				flip_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, d - 1) : -1;
				for (int i = 0; i < d; i++) begin
					if (i == flip_at)
						sw_now = ~sw_now;
					rnd_tick(1'b0, sw_now);
				end
				rnd_tick(1'b1, sw_now);
				sent += d + 1;
			end else if (kind < 7) begin
				// Switch flip held around the attack time
				sw_now = ~sw_now;
				d = $urandom_range(hlo, hhi);
				repeat (d + 1) rnd_tick(1'b1, sw_now);
				sent += d + 1;
			end else if (kind == 7) begin
				d = $urandom_range(1, 5);
				repeat (d) tick(1'b1, sw_now, 1'b0, 1'b0);
				sent += d;
			end else begin
				// Random bits on every field
				d = $urandom_range(1, 8);
				repeat (d) begin
					s = sample_t'(4'($urandom_range(0, 15)));
					send_tick(s);
					sw_now = s.switch_level;
				end
				sent += d;
			end
		end
	endtask

	initial begin
		cycles     = 0;
		burst_left = 0;
		sw_now     = 1'b1;
		hold_req   = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = REG_DETACHED;
		cfg_data   = '0;
		smp.valid  = 1'b0;
		smp.data   = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// Directed: narrow window, quick switch
		configure(0, 3, 6, 2);
		tick(1'b1, 1'b1, 1'b0, 1'b0);
		// press released on the same tick the switch is accepted: toggles cancel
		tick(1'b0, 1'b1, 1'b0, 1'b0);
		tick(1'b0, 1'b1, 1'b0, 1'b0);
		tick(1'b0, 1'b0, 1'b0, 1'b0);
		tick(1'b0, 1'b0, 1'b0, 1'b0);
		tick(1'b1, 1'b0, 1'b0, 1'b0);
		// remote set to both values, including the value already held
		tick(1'b1, 1'b0, 1'b1, 1'b0);
		tick(1'b1, 1'b0, 1'b1, 1'b1);
		tick(1'b1, 1'b0, 1'b1, 1'b1);
		tick(1'b1, 1'b0, 1'b1, 1'b0);
		// press too short
		tick(1'b0, 1'b0, 1'b0, 1'b1);
		tick(1'b0, 1'b0, 1'b0, 1'b1);
		tick(1'b1, 1'b0, 1'b0, 1'b0);
		// press too long
		repeat (8) tick(1'b0, 1'b0, 1'b0, 1'b0);
		tick(1'b1, 1'b0, 1'b0, 1'b0);
		repeat (3) tick(1'b1, 1'b1, 1'b0, 1'b0);
		sw_now = 1'b1;

		run_random(200, 1, 9, 0, 5);

		// Zero window and zero attack, switch detached from the relay
		configure(1, 0, 0, 0);
		run_random(120, 1, 3, 0, 3);

		// Default settings, around the lower press bound
		configure(0, 90, 900, 7);
		run_random(150, 87, 95, 4, 10);

		// Empty window: no press may toggle
		configure(1, 12, 4, 5);
		run_random(100, 2, 14, 2, 8);

		// Saturating press counter and longest attack, switch flipped at the press
		configure(0, 1023, 1023, 255);
		sw_now = ~sw_now;
		repeat (1100) tick(1'b0, sw_now, 1'b0, 1'b0);
		tick(1'b1, sw_now, 1'b0, 1'b0);
		repeat (20) tick(1'b1, sw_now, 1'b0, 1'b0);

		// Medium window with a long receiver hold-off at the start
		configure(0, 5, 20, 10);
		hold_req = 1'b1;
		run_random(280, 3, 22, 7, 13);

		drain();
		repeat (10) @(posedge clk);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
